@@ design/clns_pkg.sv @@
package clns_pkg;

  // Queue depths (defaults for the top-level parameters)
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  // Expander port bits
  localparam logic [7:0] PORT_RS = 8'h01;
  localparam logic [7:0] PORT_RW = 8'h02;
  localparam logic [7:0] PORT_E  = 8'h04;
  localparam logic [7:0] PORT_BL = 8'h08;

  // Set-DDRAM-address command flag
  localparam logic [7:0] POS_CMD_FLAG = 8'h80;

  typedef enum logic [1:0] {
    MODE_DATA = 2'd0,
    MODE_CMD  = 2'd1,
    MODE_POS  = 2'd2,
    MODE_INIT = 2'd3
  } mode_e;

  typedef enum logic {
    JOB_BYTE = 1'b0,
    JOB_INIT = 1'b1
  } job_kind_e;

  typedef struct packed {
    job_kind_e  kind;
    logic       is_data;
    logic [7:0] value;
  } job_t;

  typedef struct packed {
    logic [7:0] port_byte;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    SEG_NIBBLE    = 2'd0,
    SEG_BYTE      = 2'd1,
    SEG_BACKLIGHT = 2'd2,
    SEG_RW_CLEAR  = 2'd3
  } seg_e;

  // Init segments: 0..3 nibbles, 4..6 command bytes, 7 backlight, 8 RW clear
  localparam logic [3:0] INIT_FIRST_BYTE_SEG = 4'd4;
  localparam logic [3:0] INIT_LAST_NIB_SEG   = 4'd3;
  localparam logic [3:0] INIT_BL_SEG         = 4'd7;
  localparam logic [3:0] INIT_LAST_SEG       = 4'd8;

  localparam logic [2:0] BYTE_LAST_PH = 3'd6;
  localparam logic [2:0] NIB_LAST_PH  = 3'd2;
  localparam logic [2:0] LO_NIB_PH    = 3'd4;

  function automatic logic [7:0] row_base(logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0: b = 8'h00;
      2'd1: b = 8'h40;
      2'd2: b = 8'h14;
      2'd3: b = 8'h54;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] init_cmd(logic [3:0] seg);
    logic [7:0] c;
    priority if (seg == INIT_FIRST_BYTE_SEG) c = 8'h28;
    else if (seg == INIT_FIRST_BYTE_SEG + 4'd1) c = 8'h0C;
    else c = 8'h06;
    return c;
  endfunction

  function automatic logic [3:0] init_nibble(logic [3:0] seg);
    return (seg == INIT_LAST_NIB_SEG) ? 4'h2 : 4'h3;
  endfunction

  function automatic seg_e init_seg_type(logic [3:0] seg);
    seg_e t;
    priority if (seg < INIT_FIRST_BYTE_SEG) t = SEG_NIBBLE;
    else if (seg < INIT_BL_SEG) t = SEG_BYTE;
    else if (seg == INIT_BL_SEG) t = SEG_BACKLIGHT;
    else t = SEG_RW_CLEAR;
    return t;
  endfunction

endpackage

@@ design/clns_queue.sv @@
module clns_queue #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

@@ design/clns_front.sv @@
module clns_front (
  input  logic          [1:0] mode_i,
  input  logic          [7:0] byte_value_i,
  input  logic          [7:0] column_i,
  input  logic          [2:0] row_i,
  output logic                job_valid_o,
  output clns_pkg::job_t      job_o
);

  always_comb begin
    job_valid_o   = 1'b1;
    job_o.kind    = clns_pkg::JOB_BYTE;
    job_o.is_data = 1'b0;
    job_o.value   = byte_value_i;
    unique case (clns_pkg::mode_e'(mode_i))
      clns_pkg::MODE_DATA: begin
        job_o.is_data = 1'b1;
      end
      clns_pkg::MODE_CMD: begin
        job_o.is_data = 1'b0;
      end
      clns_pkg::MODE_POS: begin
        // rows 4..7 are dropped
        job_valid_o = !row_i[2];
        job_o.value = (clns_pkg::row_base(row_i[1:0]) + column_i) | clns_pkg::POS_CMD_FLAG;
      end
      clns_pkg::MODE_INIT: begin
        job_o.kind  = clns_pkg::JOB_INIT;
        job_o.value = 8'h00;
      end
    endcase
  end

endmodule

@@ design/clns_back.sv @@
module clns_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_empty_i,
  input  clns_pkg::job_t     job_i,
  output logic               job_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output clns_pkg::result_t  res_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef enum logic [1:0] {
    NP_E_HIGH = 2'd0,
    NP_LOAD   = 2'd1,
    NP_E_LOW  = 2'd2
  } nib_ph_e;

  state_e          state_q, state_d;
  clns_pkg::job_t  job_q;
  logic [3:0]      seg_q, seg_d;
  logic [2:0]      ph_q, ph_d;
  logic [7:0]      shadow_q, shadow_d;

  clns_pkg::seg_e  seg_type;
  logic [7:0]      cur_byte;
  logic [3:0]      nib;
  logic [1:0]      np;
  logic            rs_step;
  logic            ph_done;
  logic            last;
  logic            step;

  always_comb begin
    seg_type = (job_q.kind == clns_pkg::JOB_BYTE) ? clns_pkg::SEG_BYTE
                                                  : clns_pkg::init_seg_type(seg_q);
    cur_byte = (job_q.kind == clns_pkg::JOB_BYTE) ? job_q.value : clns_pkg::init_cmd(seg_q);
    rs_step  = 1'b0;
    nib      = clns_pkg::init_nibble(seg_q);
    np       = ph_q[1:0];
    ph_done  = 1'b1;
    unique case (seg_type)
      clns_pkg::SEG_NIBBLE: begin
        ph_done = (ph_q == clns_pkg::NIB_LAST_PH);
      end
      clns_pkg::SEG_BYTE: begin
        ph_done = (ph_q == clns_pkg::BYTE_LAST_PH);
        rs_step = (ph_q == 3'd0);
        if (ph_q >= clns_pkg::LO_NIB_PH) begin
          nib = cur_byte[3:0];
          np  = 2'(ph_q - clns_pkg::LO_NIB_PH);
        end else begin
          nib = cur_byte[7:4];
          np  = 2'(ph_q - 3'd1);
        end
      end
      clns_pkg::SEG_BACKLIGHT, clns_pkg::SEG_RW_CLEAR: begin
        ph_done = 1'b1;
      end
    endcase
  end

  // next shadow value for this step
  always_comb begin
    shadow_d = shadow_q;
    unique case (seg_type)
      clns_pkg::SEG_BACKLIGHT: shadow_d = shadow_q | clns_pkg::PORT_BL;
      clns_pkg::SEG_RW_CLEAR:  shadow_d = shadow_q & ~clns_pkg::PORT_RW;
      clns_pkg::SEG_NIBBLE, clns_pkg::SEG_BYTE: begin
        if (rs_step) begin
          shadow_d = job_q.is_data ? (shadow_q | clns_pkg::PORT_RS)
                                   : (shadow_q & ~clns_pkg::PORT_RS);
        end else begin
          unique case (nib_ph_e'(np))
            NP_E_HIGH: shadow_d = shadow_q | clns_pkg::PORT_E;
            NP_LOAD:   shadow_d = {nib, shadow_q[3:0]};
            NP_E_LOW:  shadow_d = shadow_q & ~clns_pkg::PORT_E;
            default:   shadow_d = shadow_q;
          endcase
        end
      end
    endcase
  end

  assign last = (job_q.kind == clns_pkg::JOB_BYTE) ? (ph_q == clns_pkg::BYTE_LAST_PH)
                                                   : (seg_q == clns_pkg::INIT_LAST_SEG);
  assign step       = (state_q == ST_RUN) && !res_full_i;
  assign res_push_o = step;
  assign res_o      = '{port_byte: shadow_d, last: last};
  assign job_pop_o  = (state_q == ST_IDLE) && !job_empty_i;

  always_comb begin
    state_d = state_q;
    seg_d   = seg_q;
    ph_d    = ph_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_pop_o) begin
          state_d = ST_RUN;
          seg_d   = '0;
          ph_d    = '0;
        end
      end
      ST_RUN: begin
        if (step) begin
          if (last) begin
            state_d = ST_IDLE;
          end else if (ph_done) begin
            ph_d  = '0;
            seg_d = seg_q + 4'd1;
          end else begin
            ph_d = ph_q + 3'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      seg_q    <= '0;
      ph_q     <= '0;
      shadow_q <= '0;
      job_q    <= '0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      ph_q    <= ph_d;
      if (step) begin
        shadow_q <= shadow_d;
      end
      if (job_pop_o) begin
        job_q <= job_i;
      end
    end
  end

endmodule

@@ design/char_lcd_expander_nibble_sequencer_unit.sv @@
// Character-LCD sequencer for an HD44780 in 4-bit mode behind an I2C port
// expander. Each accepted request becomes a run of expander port bytes
// (bit0 RS, bit1 RW, bit2 E, bit3 backlight, bits 7..4 data), one result per
// byte, with last set on the final byte of the request. Data and command
// bytes and cursor moves give 7 bytes; init gives 35; a cursor move to rows
// 4..7 gives none. The back end emits one byte per cycle while the result
// queue has room, and picks up each new request from the job queue only
// after the last byte of the previous one has gone out. The front end
// classifies requests into a small job queue and keeps taking them while
// the back end works; full rises only when that queue fills. Delays, the
// I2C transaction itself and the device address are not handled.
module char_lcd_expander_nibble_sequencer_unit #(
  parameter int unsigned JobDepth = clns_pkg::JOB_DEPTH,
  parameter int unsigned ResDepth = clns_pkg::RES_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request side
  input  logic       push,
  output logic       full,
  input  logic [1:0] mode_i,
  input  logic [7:0] byte_value_i,
  input  logic [7:0] column_i,
  input  logic [2:0] row_i,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] port_byte_o,
  output logic       last_o
);

  clns_pkg::job_t    front_job, back_job;
  logic              front_valid;
  logic              job_empty, job_pop;
  clns_pkg::result_t back_res, out_res;
  logic              res_full, res_push;

  // front: classify the request, drop off-screen cursor moves
  clns_front u_front (
    .mode_i       (mode_i),
    .byte_value_i (byte_value_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .job_valid_o  (front_valid),
    .job_o        (front_job)
  );

  // job queue between front and back
  clns_queue #(
    .T     (clns_pkg::job_t),
    .DEPTH (JobDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && front_valid),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (back_job),
    .empty_o (job_empty)
  );

  // back: port shadow and write sequencing
  clns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (back_job),
    .job_pop_o   (job_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // result queue; decouples the back end from pop
  clns_queue #(
    .T     (clns_pkg::result_t),
    .DEPTH (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign port_byte_o = out_res.port_byte;
  assign last_o      = out_res.last;

endmodule

@@ design/clns_checker.sv @@
module clns_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] port_byte_o,
  input logic       last_o
);

  // a waiting result holds until popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(port_byte_o) && $stable(last_o))
    else $error("result changed while waiting");

  // every request ends with E low
  a_last_e_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && last_o |-> !port_byte_o[2])
    else $error("request ended with E high");

  // RW is never driven high
  a_rw_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !port_byte_o[1])
    else $error("RW set on port");

  // reset empties both queues
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> empty && !full)
    else $error("queues not empty after reset");

endmodule

bind char_lcd_expander_nibble_sequencer_unit clns_checker u_clns_checker (.*);

@@ bench/char_lcd_expander_nibble_sequencer_unit_tb.sv @@
`timescale 1ns / 100ps

// LCD request sequencer bench: directed requests, then random traffic.
// Each accepted request is expanded by a local port-shadow predictor into the
// expected expander writes; the result process checks them in order.
module char_lcd_expander_nibble_sequencer_unit_tb;

  // HD44780 codes used by the init sequence and the directed tests
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_INC  = 8'h06;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_GO_4BIT    = 4'h2;
  // DDRAM start address of each display line
  localparam logic [7:0] LINE_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

  localparam int STEP_TIMEOUT = 1000;  // cycles with no request or write moving
  localparam int TAIL_CYCLES  = 60;    // settle time after the last write
  localparam int RAND_REQUESTS = 136;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] mode = clns_pkg::MODE_DATA;
  logic [7:0] byte_value = 8'h00;
  logic [7:0] column = 8'h00;
  logic [2:0] row = 3'd0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] port_byte;
  logic       last_w;

  char_lcd_expander_nibble_sequencer_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .mode_i      (mode),
    .byte_value_i(byte_value),
    .column_i    (column),
    .row_i       (row),
    .empty       (empty),
    .pop         (pop),
    .port_byte_o (port_byte),
    .last_o      (last_w)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Port-shadow predictor
  // ---------------------------------------------------------------------------
  logic [7:0]        shadow_port = 8'h00;
  clns_pkg::result_t pending_writes[$];   // expander writes not yet seen on the output

  int errors = 0;
  int writes_checked = 0;
  int req_count [4] = '{0, 0, 0, 0};
  int silent_moves = 0;            // cursor moves to rows 4..7
  int burst_left = 0;

  function automatic void queue_write();
    clns_pkg::result_t w;
    w.port_byte = shadow_port;
    w.last      = 1'b0;
    pending_writes.push_back(w);
  endfunction

  // E high (stale data), data loaded with E high, E low
  function automatic void strobe_nibble(logic [3:0] nib);
    shadow_port = shadow_port | clns_pkg::PORT_E;
    queue_write();
    shadow_port = {nib, shadow_port[3:0]};
    queue_write();
    shadow_port = shadow_port & ~clns_pkg::PORT_E;
    queue_write();
  endfunction

  function automatic void write_lcd_byte(logic [7:0] b, logic is_data);
    shadow_port = is_data ? (shadow_port | clns_pkg::PORT_RS)
                          : (shadow_port & ~clns_pkg::PORT_RS);
    queue_write();
    strobe_nibble(b[7:4]);
    strobe_nibble(b[3:0]);
  endfunction

  function automatic void predict_lcd_writes(clns_pkg::mode_e m, logic [7:0] bv,
                                             logic [7:0] col, logic [2:0] r);
    int         start_size;
    logic [7:0] addr;
    start_size = pending_writes.size();
    case (m)
      clns_pkg::MODE_DATA: write_lcd_byte(bv, 1'b1);
      clns_pkg::MODE_CMD:  write_lcd_byte(bv, 1'b0);
      clns_pkg::MODE_POS: begin
        // rows beyond the fourth are dropped without touching the port
        if (r < 3'd4) begin
          addr = LINE_OFFSET[r[1:0]] + col;   // wraps at 8 bits
          write_lcd_byte(addr | clns_pkg::POS_CMD_FLAG, 1'b0);
        end
      end
      default: begin
        strobe_nibble(NIB_WAKE);
        strobe_nibble(NIB_WAKE);
        strobe_nibble(NIB_WAKE);
        strobe_nibble(NIB_GO_4BIT);
        write_lcd_byte(CMD_FUNC_4BIT, 1'b0);
        write_lcd_byte(CMD_DISP_ON, 1'b0);
        write_lcd_byte(CMD_ENTRY_INC, 1'b0);
        shadow_port = shadow_port | clns_pkg::PORT_BL;
        queue_write();
        shadow_port = shadow_port & ~clns_pkg::PORT_RW;
        queue_write();
      end
    endcase
    if (pending_writes.size() > start_size)
      pending_writes[pending_writes.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t ERROR %s: got 0x%02h, want 0x%02h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Drives one request and holds it until accepted. push stays high on return
  // so back-to-back requests never drop it within one step.
  task automatic send_request(clns_pkg::mode_e m, logic [7:0] bv, logic [7:0] col,
                              logic [2:0] r);
    push       <= 1'b1;
    mode       <= m;
    byte_value <= bv;
    column     <= col;
    row        <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_lcd_writes(m, bv, col, r);
    req_count[m]++;
    if (m == clns_pkg::MODE_POS && r >= 3'd4) silent_moves++;
  endtask

  task automatic idle_requests(int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Bursty sender: back-to-back runs of random length, random gaps between.
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 9);
      idle_requests($urandom_range(1, 12));
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every accepted write, then pick the next pop value
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;
  int rx_style = 0;

  always @(posedge clk_i) begin
    clns_pkg::result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected write", port_byte, 8'h00);
      end else begin
        want = pending_writes.pop_front();
        if (port_byte !== want.port_byte)
          report_mismatch("port_byte", port_byte, want.port_byte);
        if (last_w !== want.last)
          report_mismatch("last", {7'd0, last_w}, {7'd0, want.last});
        writes_checked++;
      end
    end
    // stall style is redrawn at random as rx_cycle counts: free-running, coin flip,
    // mostly stalled, or one pop in three
    rx_cycle++;
    if (rx_cycle % 48 == 0) rx_style = $urandom_range(0, 3);
    case (rx_style)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= ($urandom_range(0, 3) == 0);
      default: pop <= (rx_cycle % 3 == 0);
    endcase
  end

  // Watchdog: consecutive cycles in which neither side moves anything
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STEP_TIMEOUT) begin
        $display("%0t timeout, %0d writes outstanding", $realtime,
                 pending_writes.size());
        $display("char_lcd_expander_nibble_sequencer_unit: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Data bytes straight out of reset, shadow still zero
  task automatic test_data_bytes();
    send_request(clns_pkg::MODE_DATA, 8'h00, 8'hFF, 3'd7);
    send_request(clns_pkg::MODE_DATA, 8'hFF, 8'h00, 3'd0);
    pace_sender();
    send_request(clns_pkg::MODE_DATA, 8'hA5, 8'h5A, 3'd5);
  endtask

  task automatic test_commands();
    send_request(clns_pkg::MODE_CMD, CMD_CLEAR, 8'h00, 3'd0);
    send_request(clns_pkg::MODE_CMD, 8'hFF, 8'hFF, 3'd7);
    pace_sender();
    send_request(clns_pkg::MODE_CMD, 8'h00, 8'h80, 3'd3);
  endtask

  // Every line base, column wrap, and the out-of-range rows
  task automatic test_cursor();
    for (int r = 0; r < 4; r++)
      send_request(clns_pkg::MODE_POS, 8'hFF, 8'h00, r[2:0]);
    send_request(clns_pkg::MODE_POS, 8'h00, 8'hFF, 3'd3);   // 0x54 + 0xFF wraps
    send_request(clns_pkg::MODE_POS, 8'hFF, 8'hC0, 3'd1);   // wraps to 0x00
    for (int r = 4; r < 8; r++)
      send_request(clns_pkg::MODE_POS, 8'hAA, 8'h27, r[2:0]);
    send_request(clns_pkg::MODE_POS, 8'h55, 8'h7F, 3'd2);
  endtask

  task automatic test_init();
    send_request(clns_pkg::MODE_INIT, 8'hFF, 8'hFF, 3'd7);
    send_request(clns_pkg::MODE_DATA, 8'h41, 8'h00, 3'd0);  // data with backlight set
    idle_requests(3);
    send_request(clns_pkg::MODE_INIT, 8'h00, 8'h00, 3'd0);
  endtask

  // Sender holds off until the block has drained everything
  task automatic test_drain_pause();
    send_request(clns_pkg::MODE_DATA, 8'h3C, 8'h00, 3'd0);
    send_request(clns_pkg::MODE_POS, 8'h00, 8'h10, 3'd2);
    wait_drained();
    send_request(clns_pkg::MODE_CMD, CMD_CLEAR, 8'h00, 3'd0);
  endtask

  task automatic test_random_traffic();
    int              counted;
    int              pick;
    clns_pkg::mode_e m;
    logic [7:0]      bv;
    logic [7:0]      col;
    logic [2:0]      r;
    counted = 0;
    while (counted < RAND_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      m = clns_pkg::MODE_DATA;
      else if (pick < 68) m = clns_pkg::MODE_CMD;
      else if (pick < 94) m = clns_pkg::MODE_POS;
      else                m = clns_pkg::MODE_INIT;
      bv  = 8'($urandom_range(0, 255));
      col = 8'($urandom_range(0, 255));
      r   = 3'($urandom_range(0, 7));
      if (m == clns_pkg::MODE_CMD && $urandom_range(0, 5) == 0) bv = CMD_CLEAR;
      // mostly legal rows so moves reach the port
      if (m == clns_pkg::MODE_POS && $urandom_range(0, 6) != 0)
        r = 3'($urandom_range(0, 3));
      send_request(m, bv, col, r);
      if (!(m == clns_pkg::MODE_POS && r >= 3'd4)) counted++;
      if (counted == RAND_REQUESTS / 2) wait_drained();
      pace_sender();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_data_bytes();
    test_commands();
    test_cursor();
    test_init();
    test_drain_pause();
    test_random_traffic();

    // let everything drain, then watch for stray writes
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("requests: %0d data, %0d command, %0d cursor (%0d off-screen), %0d init",
             req_count[clns_pkg::MODE_DATA], req_count[clns_pkg::MODE_CMD],
             req_count[clns_pkg::MODE_POS], silent_moves,
             req_count[clns_pkg::MODE_INIT]);
    $display("expander writes checked: %0d, errors: %0d", writes_checked, errors);
    if (errors == 0 && pending_writes.size() == 0)
      $display("char_lcd_expander_nibble_sequencer_unit: match");
    else
      $display("char_lcd_expander_nibble_sequencer_unit: mismatch");
    $finish;
  end

endmodule
